>>> rtl/hough_circle_voting_defines.svh
// ----------------------------------------------------------------------------
// hough circle voting assertion macros
// shared property forms for the accumulator checks
// ----------------------------------------------------------------------------
`ifndef HOUGH_CIRCLE_VOTING_DEFINES_SVH
`define HOUGH_CIRCLE_VOTING_DEFINES_SVH

// same-cycle implication
`define HCV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hcv_pkg.sv
// ----------------------------------------------------------------------------
// hcv_pkg
// sizes, register map, sequencer states and sine table of the accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package hcv_pkg;

	localparam int ROWS    = 64;
	localparam int COLS    = 64;
	localparam int RADII   = 16;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int RADII_W = $clog2(RADII);
	localparam int SLOT_W  = $clog2(RADII + 1);
	localparam int ADDR_W  = RADII_W + ROW_W + COL_W;
	localparam int DEPTH   = RADII * ROWS * COLS;
	localparam int EDGE_LEVEL = 250;
	localparam int LAST_DEG   = 359;
	localparam int DEG_QUARTER = 90;

	localparam logic [1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_MIN_RADIUS = 2'd1;
	localparam logic [1:0] REG_MAX_RADIUS = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_NEXT,
		S_COS,
		S_SIN,
		S_READ,
		S_WRITE,
		S_QWRITE,
		S_DONE
	} state_t;

	// quarter-wave sine, q1.14
	localparam logic [14:0] QSINE [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14329, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

endpackage

`default_nettype wire

>>> rtl/hcv_trig_unit.sv
// ----------------------------------------------------------------------------
// hcv_trig_unit
// shared unit: rounded radius times sine of a whole-degree angle
// ----------------------------------------------------------------------------
`default_nettype none

module hcv_trig_unit import hcv_pkg::*; (
	input  wire logic [5:0]        radius,
	input  wire logic [8:0]        angle,   // 0..449 degrees
	output logic signed [7:0]      offset
);

	logic [8:0]  deg;
	logic [6:0]  idx;
	logic        neg;
	logic [20:0] prod;
	logic [21:0] biased;
	logic [6:0]  mag;

	always_comb begin
		deg = (angle >= 9'd360) ? angle - 9'd360 : angle;
		if (deg <= 9'd90) begin
			idx = deg[6:0];
			neg = 1'b0;
		end else if (deg <= 9'd180) begin
			idx = 7'(9'd180 - deg);
			neg = 1'b0;
		end else if (deg <= 9'd270) begin
			idx = 7'(deg - 9'd180);
			neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - deg);
			neg = 1'b1;
		end
		prod   = 21'(radius) * 21'(QSINE[idx]);
		biased = 22'(prod) + 22'd8192;
		mag    = biased[20:14];
		offset = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

`default_nettype wire

>>> rtl/hough_circle_voting.sv
// ----------------------------------------------------------------------------
// hough_circle_voting
// hough circle accumulator with vote and query-and-clear commands
// ----------------------------------------------------------------------------
// After reset the block sweeps the 65536-cell accumulator to zero, one cell a
// cycle, and takes no beat until the sweep is done. A query beat reads its
// counter, writes it back as zero and then loads the result. An edge-pixel
// vote beat, for each radius tried, sends each of the 360 degrees twice
// through the shared sine/multiply unit and, for each centre that lands in
// the image, does a read-modify-write of the counter memory. A non-edge pixel
// casts no votes and goes straight to its result. One beat is processed at a
// time; the result register frees the input side once the result is loaded.
`default_nettype none

module hough_circle_voting import hcv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // pixel_row, pixel_col, pixel_value, radius_index
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // hit, votes, radius, center_row, center_col, pad
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	`include "hough_circle_voting_defines.svh"

	state_t state_q, state_d;

	logic [15:0]       thr_q;
	logic [5:0]        min_radius_q;
	logic [5:0]        max_radius_q;

	logic [ADDR_W-1:0] clr_q;
	logic [8:0]        deg_q;
	logic [SLOT_W-1:0] slot_q;
	logic              cmd_q;
	logic [5:0]        row_q;
	logic [5:0]        col_q;
	logic [6:0]        qrad_q;
	logic              qin_q;
	logic [ADDR_W-1:0] addr_q;
	logic signed [7:0] cos_q;
	logic [15:0]       votes_q;
	logic              out_valid_q;
	logic [39:0]       out_q;

	logic [15:0]       mem [0:DEPTH-1];
	logic [15:0]       rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;

	logic              s_acc;
	logic              cfg_wr;
	logic [6:0]        r_ext;
	logic              radius_ok;
	logic [8:0]        angle;
	logic signed [7:0] off;
	logic signed [8:0] cr;
	logic signed [8:0] cc;
	logic              in_img;
	logic              last_deg;
	logic              out_free;

	hcv_trig_unit u_trig (
		.radius (r_ext[5:0]),
		.angle  (angle),
		.offset (off)
	);

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || m_tready;

	assign r_ext     = 7'(min_radius_q) + 7'(slot_q);
	assign radius_ok = (32'(slot_q) < RADII) && (r_ext < {1'b0, max_radius_q});
	assign angle     = (state_q == S_COS) ? deg_q + 9'(DEG_QUARTER) : deg_q;
	assign cr        = $signed({3'b000, row_q}) - 9'(cos_q);
	assign cc        = $signed({3'b000, col_q}) - 9'(off);
	assign in_img    = !cr[8] && (cr[7:0] < 8'(ROWS)) && !cc[8] && (cc[7:0] < 8'(COLS));
	assign last_deg  = (deg_q == 9'(LAST_DEG));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= 16'd1;
			min_radius_q <= 6'd0;
			max_radius_q <= 6'd16;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_THRESHOLD:  thr_q        <= pwdata[15:0];
				REG_MIN_RADIUS: min_radius_q <= pwdata[5:0];
				REG_MAX_RADIUS: max_radius_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD:  prdata = {16'd0, thr_q};
			REG_MIN_RADIUS: prdata = {26'd0, min_radius_q};
			REG_MAX_RADIUS: prdata = {26'd0, max_radius_q};
			default:        prdata = 32'd0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		waddr   = addr_q;
		wdata   = 16'd0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_acc) begin
					if (s_tuser) state_d = S_READ;
					else if (s_tdata[19:12] > 8'(EDGE_LEVEL)) state_d = S_NEXT;
					else state_d = S_DONE;
				end
			end
			S_NEXT: state_d = radius_ok ? S_COS : S_DONE;
			S_COS:  state_d = S_SIN;
			S_SIN: begin
				if (in_img) state_d = S_READ;
				else        state_d = last_deg ? S_NEXT : S_COS;
			end
			S_READ: state_d = cmd_q ? S_QWRITE : S_WRITE;
			S_WRITE: begin
				mem_we  = 1'b1;
				wdata   = (rdata_q == 16'hFFFF) ? rdata_q : rdata_q + 16'd1;
				state_d = last_deg ? S_NEXT : S_COS;
			end
			S_QWRITE: begin
				mem_we  = qin_q;
				state_d = S_DONE;
			end
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_tready)                 out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q  <= s_tuser;
				row_q  <= s_tdata[5:0];
				col_q  <= s_tdata[11:6];
				qrad_q <= 7'(min_radius_q) + 7'(s_tdata[23:20]);
				qin_q  <= (32'(s_tdata[23:20]) < RADII) && (32'(s_tdata[5:0]) < ROWS)
					&& (32'(s_tdata[11:6]) < COLS);
				addr_q <= {s_tdata[RADII_W+19:20], s_tdata[5:0], s_tdata[11:6]};
				deg_q  <= 9'd0;
				slot_q <= '0;
			end
			S_COS: cos_q <= off;
			S_SIN: begin
				if (in_img) begin
					addr_q <= {slot_q[RADII_W-1:0], cr[5:0], cc[5:0]};
				end else if (last_deg) begin
					deg_q  <= 9'd0;
					slot_q <= slot_q + 1'b1;
				end else begin
					deg_q <= deg_q + 9'd1;
				end
			end
			S_WRITE: begin
				if (last_deg) begin
					deg_q  <= 9'd0;
					slot_q <= slot_q + 1'b1;
				end else begin
					deg_q <= deg_q + 9'd1;
				end
			end
			S_QWRITE: votes_q <= qin_q ? rdata_q : 16'd0;
			S_DONE: begin
				if (out_free) begin
					if (cmd_q) begin
						out_q <= {4'd0, col_q, row_q, qrad_q, votes_q,
							qin_q && (votes_q >= thr_q)};
					end else begin
						out_q <= 40'd0;
					end
				end
			end
			default: ;
		endcase
	end

	// counter memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[addr_q];
	end

	`HCV_ASSERT_NOW(a_no_beat_in_clear, state_q == S_CLEAR, !s_tready, "beat taken during clear")
	`HCV_ASSERT_NEXT(a_edge_starts_vote, s_acc && !s_tuser && (s_tdata[19:12] > 8'(EDGE_LEVEL)), state_q == S_NEXT, "edge pixel did not start voting")
	`HCV_ASSERT_NOW(a_slot_bound, state_q != S_CLEAR && state_q != S_IDLE, 32'(slot_q) <= RADII, "radius slot overrun")
	`HCV_ASSERT_NOW(a_vote_nonzero, state_q == S_WRITE, mem_we && wdata != 16'd0, "vote wrote zero")

endmodule

`default_nettype wire

>>> tb/tb_hough_circle_voting.sv
// ----------------------------------------------------------------------------
// tb_hough_circle_voting
// stream level check of the hough circle accumulator
// ----------------------------------------------------------------------------
// A walked list of directed beats and register writes comes first: reset
// contents, non-edge and edge pixels, image corners, the extremes of the
// radius registers, an empty radius range, threshold zero and counter
// saturation. Random phases follow, with small radius ranges, edge votes and
// queries aimed at the circles just voted. Every result is compared with an
// in-bench accumulator model or a fixed expected result. Both stream sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_hough_circle_voting;
	import hcv_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT     = 40;
	localparam int PHASES      = 6;
	localparam int PHASE_BEATS = 17;

	typedef struct packed {
		logic        hit;
		logic [15:0] votes;
		logic [6:0]  radius;
		logic [5:0]  center_row;
		logic [5:0]  center_col;
	} circle_result_t;

	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e      kind;
		logic           cmd;
		logic [5:0]     row;
		logic [5:0]     col;
		logic [7:0]     value;
		logic [3:0]     ridx;
		logic [1:0]     reg_sel;
		logic [15:0]    reg_val;
		bit             typed;
		circle_result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // pixel_row, pixel_col, pixel_value, radius_index
	logic        s_tuser = 1'b0; // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // hit, votes, radius, center_row, center_col, pad
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	hough_circle_voting DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [15:0]    tally [0:DEPTH-1];
	logic [15:0]    thr_model;
	logic [5:0]     rmin_model;
	logic [5:0]     rmax_model;
	circle_result_t pending_results [$];
	stim_row_t      stim_rows [$];
	int errors;
	int results_seen;
	int beats_sent;
	int edge_votes;
	int hits_seen;
	int cycles;
	int hold_left;
	int stall_left;
	bit held;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int sine_q14(int deg);
		deg = deg % 360;
		if (deg <= 90) return int'(QSINE[deg]);
		if (deg <= 180) return int'(QSINE[180 - deg]);
		if (deg <= 270) return -int'(QSINE[deg - 180]);
		return -int'(QSINE[360 - deg]);
	endfunction

	function automatic int round_q14(int p);
		if (p >= 0) return (p + 8192) / 16384;
		return -((-p + 8192) / 16384);
	endfunction

	task automatic cast_circle_votes(int row, int col);
		int slot, cr, cc, idx;
		for (int r = rmin_model; r < rmax_model; r++) begin
			slot = r - rmin_model;
			if (slot >= RADII) break;
			for (int d = 0; d < 360; d++) begin
				cr = row - round_q14(r * sine_q14(d + 90));
				cc = col - round_q14(r * sine_q14(d));
				if (cr >= 0 && cr < ROWS && cc >= 0 && cc < COLS) begin
					idx = (slot * ROWS + cr) * COLS + cc;
					if (tally[idx] != 16'hffff) tally[idx] = tally[idx] + 16'd1;
				end
			end
		end
	endtask

	task automatic predict_result(input logic cmd, input logic [5:0] row,
			input logic [5:0] col, input logic [7:0] value, input logic [3:0] ridx,
			output circle_result_t res);
		int idx;
		res = '0;
		if (cmd == 1'b0) begin
			if (value > EDGE_LEVEL) begin
				cast_circle_votes(row, col);
				edge_votes++;
			end
		end else begin
			res.radius = 7'(rmin_model + ridx);
			res.center_row = row;
			res.center_col = col;
			idx = (ridx * ROWS + row) * COLS + col;
			res.votes = tally[idx];
			res.hit = (tally[idx] >= thr_model);
			tally[idx] = '0;
		end
	endtask

	task automatic send_beat(logic cmd, logic [5:0] row, logic [5:0] col,
			logic [7:0] value, logic [3:0] ridx, bit typed, circle_result_t typed_res);
		int k, gap;
		circle_result_t res;
		k = $urandom_range(0, 99);
		gap = (k < 55) ? 0 : (k < 92) ? $urandom_range(1, 4) : $urandom_range(20, 100);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {ridx, value, col, row};
		do @(posedge clk); while (!s_tready);
		predict_result(cmd, row, col, value, ridx, res);
		pending_results.push_back(typed ? typed_res : res);
		beats_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] sel, logic [15:0] value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_THRESHOLD:  thr_model = value;
			REG_MIN_RADIUS: rmin_model = value[5:0];
			REG_MAX_RADIUS: rmax_model = value[5:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic void add_beat(logic cmd, logic [5:0] row, logic [5:0] col,
			logic [7:0] value, logic [3:0] ridx, bit typed = 0,
			circle_result_t res = '0);
		stim_row_t s;
		s = '{ROW_BEAT, cmd, row, col, value, ridx, 2'd0, 16'd0, typed, res};
		stim_rows.push_back(s);
	endfunction

	function automatic void add_reg(logic [1:0] sel, logic [15:0] value);
		stim_row_t s;
		s = '{ROW_REG, 1'b0, 6'd0, 6'd0, 8'd0, 4'd0, sel, value, 1'b0, '0};
		stim_rows.push_back(s);
	endfunction

	// results side: check and random back-pressure
	always @(posedge clk) begin
		circle_result_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.hit        = m_tdata[0];
				got.votes      = m_tdata[16:1];
				got.radius     = m_tdata[23:17];
				got.center_row = m_tdata[29:24];
				got.center_col = m_tdata[35:30];
				results_seen <= results_seen + 1;
				if (got.hit) hits_seen <= hits_seen + 1;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						errors++;
					end
					if (got.votes !== want.votes) begin
						$error("votes: expected %0d, got %0d", want.votes, got.votes);
						errors++;
					end
					if (got.radius !== want.radius) begin
						$error("radius: expected %0d, got %0d", want.radius, got.radius);
						errors++;
					end
					if (got.center_row !== want.center_row) begin
						$error("center_row: expected %0d, got %0d",
							want.center_row, got.center_row);
						errors++;
					end
					if (got.center_col !== want.center_col) begin
						$error("center_col: expected %0d, got %0d",
							want.center_col, got.center_col);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!held && results_seen == HOLD_AT) begin
				held <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				int k;
				k = $urandom_range(0, 99);
				if (k < 60) m_tready <= 1'b1;
				else begin
					m_tready <= 1'b0;
					stall_left <= (k < 92) ? $urandom_range(0, 3) : $urandom_range(20, 80);
				end
			end
		end
	end

	initial begin
		logic [5:0] er, ec, cr, cc;
		logic [3:0] slot;
		int span, k, r, d, lo, hi;
		circle_result_t z;
		z = '0;
		errors = 0;
		results_seen = 0;
		beats_sent = 0;
		edge_votes = 0;
		hits_seen = 0;
		cycles = 0;
		hold_left = 0;
		stall_left = 0;
		held = 0;
		for (int i = 0; i < DEPTH; i++) tally[i] = '0;
		thr_model = 16'd1;
		rmin_model = 6'd0;
		rmax_model = 6'd16;

		// reset contents, pixel threshold, full radius sweep, corners
		add_beat(1'b1, 6'd0, 6'd0, 8'd0, 4'd0, 1, z);
		add_beat(1'b1, 6'd63, 6'd63, 8'd255, 4'd15, 1, '{0, 16'd0, 7'd15, 6'd63, 6'd63});
		add_beat(1'b0, 6'd32, 6'd32, 8'd250, 4'd0, 1, z);
		add_beat(1'b0, 6'd32, 6'd32, 8'd255, 4'd15, 1, z);
		add_beat(1'b1, 6'd32, 6'd32, 8'd0, 4'd0);
		add_beat(1'b1, 6'd32, 6'd32, 8'd0, 4'd0);
		add_beat(1'b1, 6'd22, 6'd32, 8'd0, 4'd10);
		add_beat(1'b1, 6'd32, 6'd47, 8'd0, 4'd15);
		add_beat(1'b0, 6'd0, 6'd0, 8'd251, 4'd0, 1, z);
		add_beat(1'b0, 6'd63, 6'd63, 8'd255, 4'd0, 1, z);
		add_beat(1'b1, 6'd63, 6'd63, 8'd0, 4'd0);
		add_beat(1'b1, 6'd0, 6'd3, 8'd0, 4'd3);
		// top radii, threshold zero and maximum
		add_reg(REG_MIN_RADIUS, 16'd60);
		add_reg(REG_MAX_RADIUS, 16'd63);
		add_reg(REG_THRESHOLD, 16'd0);
		add_beat(1'b0, 6'd0, 6'd63, 8'd255, 4'd0, 1, z);
		add_beat(1'b1, 6'd60, 6'd63, 8'd0, 4'd0);
		add_beat(1'b1, 6'd10, 6'd10, 8'd0, 4'd1);
		add_reg(REG_THRESHOLD, 16'd65535);
		add_beat(1'b1, 6'd0, 6'd3, 8'd0, 4'd2);
		// empty radius range
		add_reg(REG_MIN_RADIUS, 16'd63);
		add_reg(REG_MAX_RADIUS, 16'd0);
		add_beat(1'b0, 6'd20, 6'd20, 8'd255, 4'd0, 1, z);
		add_beat(1'b1, 6'd20, 6'd20, 8'd0, 4'd0);
		// radius zero driven into saturation
		add_reg(REG_MIN_RADIUS, 16'd0);
		add_reg(REG_MAX_RADIUS, 16'd1);
		for (int i = 0; i < 183; i++) add_beat(1'b0, 6'd5, 6'd7, 8'd255, 4'd0, 1, z);
		add_beat(1'b1, 6'd5, 6'd7, 8'd0, 4'd0, 1, '{1, 16'hffff, 7'd0, 6'd5, 6'd7});
		add_beat(1'b1, 6'd5, 6'd7, 8'd0, 4'd0, 1, '{0, 16'd0, 7'd0, 6'd5, 6'd7});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_REG)
				write_reg(stim_rows[i].reg_sel, stim_rows[i].reg_val);
			else
				send_beat(stim_rows[i].cmd, stim_rows[i].row, stim_rows[i].col,
					stim_rows[i].value, stim_rows[i].ridx, stim_rows[i].typed,
					stim_rows[i].res);
		end

		er = 6'd32;
		ec = 6'd32;
		for (int p = 0; p < PHASES; p++) begin
			lo = $urandom_range(0, 60);
			span = $urandom_range(0, 3);
			hi = (lo + span > 63) ? 63 : lo + span;
			write_reg(REG_MIN_RADIUS, 16'(lo));
			write_reg(REG_MAX_RADIUS, 16'(hi));
			k = $urandom_range(0, 3);
			write_reg(REG_THRESHOLD, (k == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 4)));
			for (int i = 0; i < PHASE_BEATS; i++) begin
				k = $urandom_range(0, 99);
				if (k < 25) begin
					er = 6'($urandom_range(0, 63));
					ec = 6'($urandom_range(0, 63));
					send_beat(1'b0, er, ec, 8'($urandom_range(251, 255)),
						4'($urandom), 0, z);
				end else if (k < 40) begin
					send_beat(1'b0, 6'($urandom), 6'($urandom),
						8'($urandom_range(0, 250)), 4'($urandom), 0, z);
				end else if (k < 82) begin
					slot = 4'($urandom_range(0, span));
					r = rmin_model + slot;
					d = $urandom_range(0, 359);
					cr = 6'(er - round_q14(r * sine_q14(d + 90)));
					cc = 6'(ec - round_q14(r * sine_q14(d)));
					send_beat(1'b1, cr, cc, 8'($urandom), slot, 0, z);
				end else begin
					send_beat(1'b1, 6'($urandom), 6'($urandom), 8'($urandom),
						4'($urandom), 0, z);
				end
			end
		end

		drain_results();
		repeat (50) @(posedge clk);
		$display("%0d beats sent, %0d edge pixels voted, %0d results checked",
			beats_sent, edge_votes, results_seen);
		$display("%0d queries hit, including saturation and a long result stall",
			hits_seen);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
